FILE: sv/rrwt_pkg.sv
// Shared widths and controller/datapath interface types for the round-robin wait time unit.
`default_nettype none

package rrwt_pkg;

  localparam int unsigned QW  = 16;  // time quantum width
  localparam int unsigned IDW = 8;   // process id width
  localparam int unsigned BIW = 16;  // burst time port width
  localparam int unsigned TW  = 20;  // time result width

  typedef struct packed {
    logic load;    // accept an input word
    logic begin_b; // batch closed, point at first process
    logic cap;     // capture process under evaluation, init remainder unit
    logic div;     // one remainder step
    logic pad;     // form slice limits, clear scan
    logic scan;    // sweep other processes and accumulate
    logic emit;    // register result, advance process
  } rrwt_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic last_proc;
  } rrwt_sts_t;

endpackage

`default_nettype wire

FILE: sv/round_robin_wait_time_calc_unit.sv
// Top level of the round-robin wait time unit: controller plus datapath.
// Load: one word per cycle while busy_o is low; the word with last_process_i closes the batch.
// Batch of n: each stored process passes read, capture, the remainder unit, slice limits,
// the store sweep over all n stored processes and emit; emit registers the result for the strobe.
// Results come one per process in load order, each a one-cycle strobe; the receiver cannot stall.
// Reset clears the process count and control state and sets the quantum to 5.
`default_nettype none

module round_robin_wait_time_calc_unit
  import rrwt_pkg::*;
#(
  parameter int unsigned MAX_PROCS  = 16,
  parameter int unsigned BURST_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire logic [IDW-1:0] process_id_i,
  input  wire logic [BIW-1:0] burst_time_i,
  input  wire logic           last_process_i,
  input  wire logic           cfg_we_i,
  input  wire logic [QW-1:0]  cfg_wdata_i,
  output logic                result_valid_o,
  output logic [IDW-1:0]      result_id_o,
  output logic [TW-1:0]       waiting_time_o,
  output logic [TW-1:0]       turnaround_time_o,
  output logic                last_result_o
);

  rrwt_cmd_t cmd;
  rrwt_sts_t sts;

  rrwt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .last_process_i (last_process_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy_o)
  );

  rrwt_datapath #(
    .MAX_PROCS  (MAX_PROCS),
    .BURST_BITS (BURST_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .process_id_i      (process_id_i),
    .burst_time_i      (burst_time_i),
    .result_valid_o    (result_valid_o),
    .result_id_o       (result_id_o),
    .waiting_time_o    (waiting_time_o),
    .turnaround_time_o (turnaround_time_o),
    .last_result_o     (last_result_o)
  );

endmodule

`default_nettype wire

FILE: sv/rrwt_ctrl.sv
// Controller state machine for the round-robin wait time unit.
`default_nettype none

module rrwt_ctrl
  import rrwt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire logic      last_process_i,
  input  wire rrwt_sts_t sts_i,
  output rrwt_cmd_t      cmd_o,
  output logic           busy_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CAP  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PAD  = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_process_i) begin
            cmd_o.begin_b = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_CAP;
      end
      S_CAP: begin
        cmd_o.cap = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_PAD;
        end
      end
      S_PAD: begin
        cmd_o.pad = 1'b1;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = sts_i.last_proc ? S_IDLE : S_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: sv/rrwt_datapath.sv
// Datapath: process store, remainder unit, slice limits and completion time accumulator.
`default_nettype none

module rrwt_datapath
  import rrwt_pkg::*;
#(
  parameter int unsigned MAX_PROCS  = 16,
  parameter int unsigned BURST_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rrwt_cmd_t      cmd_i,
  output rrwt_sts_t           sts_o,
  input  wire logic           cfg_we_i,
  input  wire logic [QW-1:0]  cfg_wdata_i,
  input  wire logic [IDW-1:0] process_id_i,
  input  wire logic [BIW-1:0] burst_time_i,
  output logic                result_valid_o,
  output logic [IDW-1:0]      result_id_o,
  output logic [TW-1:0]       waiting_time_o,
  output logic [TW-1:0]       turnaround_time_o,
  output logic                last_result_o
);

  localparam int unsigned IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CW  = $clog2(MAX_PROCS + 1);
  localparam int unsigned DCW = $clog2(BURST_BITS + 1);
  localparam int unsigned LW  = ((BURST_BITS > QW) ? BURST_BITS : QW) + 1;
  localparam int unsigned BB  = BURST_BITS;

  logic [BB-1:0]  burst_mem [MAX_PROCS];
  logic [IDW-1:0] id_mem    [MAX_PROCS];

  logic [QW-1:0]  quant_q;
  logic [CW-1:0]  cnt_q;
  logic [CW-1:0]  i_q;
  logic [CW-1:0]  j_q;
  logic [CW-1:0]  jd_q;
  logic           v_q;
  logic [DCW-1:0] dcnt_q;
  logic           valid_q;

  logic [BB-1:0]  b_rd_q;
  logic [IDW-1:0] id_rd_q;
  logic [BB-1:0]  bi_q;
  logic [IDW-1:0] idi_q;
  logic [QW-1:0]  qe_q;
  logic [BB-1:0]  dq_q;
  logic [QW-1:0]  rem_q;
  logic [LW-1:0]  lim_hi_q;
  logic [TW-1:0]  t_q;
  logic [IDW-1:0] res_id_q;
  logic [TW-1:0]  res_wt_q;
  logic [TW-1:0]  res_tat_q;
  logic           res_last_q;

  logic          full;
  logic          last_proc;
  logic [IW-1:0] rd_addr;
  logic [QW:0]   shifted;
  logic          ge;
  logic [QW-1:0] pad_v;
  logic [LW-1:0] lim_lo;
  logic [LW-1:0] lim_sel;
  logic [LW-1:0] bj;
  logic [LW-1:0] mn;

  assign full      = (cnt_q == CW'(MAX_PROCS));
  assign last_proc = ((i_q + CW'(1)) == cnt_q);
  assign rd_addr   = cmd_i.scan ? j_q[IW-1:0] : i_q[IW-1:0];
  assign shifted   = {rem_q, dq_q[BB-1]};
  assign ge        = (shifted >= {1'b0, qe_q});
  assign pad_v     = (rem_q != '0) ? (qe_q - rem_q) : '0;
  assign lim_lo    = lim_hi_q - LW'(qe_q);
  assign lim_sel   = (jd_q < i_q) ? lim_hi_q : lim_lo;
  assign bj        = LW'(b_rd_q);
  assign mn        = (bj < lim_sel) ? bj : lim_sel;

  assign sts_o.div_done  = (dcnt_q == '0);
  assign sts_o.scan_done = (j_q == cnt_q) && !v_q;
  assign sts_o.last_proc = last_proc;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q <= QW'(5);
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      v_q     <= 1'b0;
      dcnt_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quant_q <= cfg_wdata_i;
      end
      if (cmd_i.load && !full) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.emit && last_proc) begin
        cnt_q <= '0;
      end
      if (cmd_i.begin_b) begin
        i_q <= '0;
      end else if (cmd_i.emit) begin
        i_q <= i_q + CW'(1);
      end
      if (cmd_i.cap) begin
        dcnt_q <= DCW'(BURST_BITS);
      end else if (cmd_i.div && (dcnt_q != '0)) begin
        dcnt_q <= dcnt_q - DCW'(1);
      end
      if (cmd_i.pad) begin
        j_q <= '0;
        v_q <= 1'b0;
      end else if (cmd_i.scan) begin
        if (j_q != cnt_q) begin
          j_q <= j_q + CW'(1);
          v_q <= 1'b1;
        end else begin
          v_q <= 1'b0;
        end
      end
      valid_q <= cmd_i.emit;
    end
  end

  // store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      burst_mem[cnt_q[IW-1:0]] <= BB'(burst_time_i);
      id_mem[cnt_q[IW-1:0]]    <= process_id_i;
    end
    b_rd_q  <= burst_mem[rd_addr];
    id_rd_q <= id_mem[rd_addr];
  end

  // arithmetic
  always_ff @(posedge clk_i) begin
    jd_q <= j_q;
    if (cmd_i.cap) begin
      bi_q  <= b_rd_q;
      idi_q <= id_rd_q;
      qe_q  <= (quant_q == '0) ? QW'(1) : quant_q;
      dq_q  <= b_rd_q;
      rem_q <= '0;
    end else if (cmd_i.div && (dcnt_q != '0)) begin
      rem_q <= ge ? QW'(shifted - {1'b0, qe_q}) : shifted[QW-1:0];
      dq_q  <= dq_q << 1;
    end
    if (cmd_i.pad) begin
      lim_hi_q <= LW'(bi_q) + LW'(pad_v);
      t_q      <= TW'(bi_q);
    end else if (cmd_i.scan && v_q && (jd_q != i_q)) begin
      t_q <= t_q + TW'(mn);
    end
    if (cmd_i.emit) begin
      res_id_q   <= idi_q;
      res_last_q <= last_proc;
      if (bi_q == '0) begin
        res_wt_q  <= '0;
        res_tat_q <= '0;
      end else begin
        res_wt_q  <= t_q - TW'(bi_q);
        res_tat_q <= t_q;
      end
    end
  end

  assign result_valid_o    = valid_q;
  assign result_id_o       = res_id_q;
  assign waiting_time_o    = res_wt_q;
  assign turnaround_time_o = res_tat_q;
  assign last_result_o     = res_last_q;

endmodule

`default_nettype wire

FILE: sv/rrwt_checker.sv
// Port-level checker for the round-robin wait time unit, bound to the top level.
`default_nettype none

module rrwt_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic last_process_i,
  input wire logic result_valid_o,
  input wire logic last_result_o
);

  a_word_no_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !last_process_i |=> !busy_o)
    else $error("busy raised by a word that does not close the batch");

  a_last_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_process_i |=> busy_o)
    else $error("batch close did not start computation");

  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |-> busy_o)
    else $error("unit went idle before the final result");

  a_fell_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o && last_result_o)
    else $error("unit went idle without delivering the final result");

  a_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobes on consecutive cycles");

endmodule

bind round_robin_wait_time_calc_unit rrwt_checker u_rrwt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .last_process_i (last_process_i),
  .result_valid_o (result_valid_o),
  .last_result_o  (last_result_o)
);

`default_nettype wire
